// File: rtl/srit_pkg.sv
// Shared types and constants for the striding receive in-order tracker.
// No dependencies; used by srit_ctrl, srit_dp and the top level.
`default_nettype none

package srit_pkg;

    localparam int STRIDES_PER_BUFFER = 1024;
    localparam int STRIDE_BYTES       = 64;
    localparam int NUM_BUFFERS        = 16;

    localparam int BUF_W      = 4;
    localparam int OFF_W      = 10;
    localparam int POS_W      = BUF_W + OFF_W;
    localparam int LEN_W      = 17;
    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 12;
    localparam int STRIDE_SH  = 6;

    // mark storage: one 64-bit word per row, one valid flop per row
    localparam int WORD_BITS  = 64;
    localparam int WORD_IDX_W = 6;
    localparam int ROW_W      = POS_W - WORD_IDX_W;
    localparam int NUM_ROWS   = 1 << ROW_W;
    localparam int ROW_SH     = OFF_W - WORD_IDX_W;
    localparam int CL_W       = CNT_W + LEN_W;

    typedef enum logic [1:0] {
        MODE_RECV   = 2'd0,
        MODE_NOOP   = 2'd1,
        MODE_TAKE   = 2'd2,
        MODE_REPOST = 2'd3
    } t_mode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;   // capture item, launch memory reads
        logic commit;   // update state, load result register
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/srit_ctrl.sv
// Controller FSM for the tracker: input/output handshake and step sequencing.
// Depends on srit_pkg.
`default_nettype none

module srit_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output srit_pkg::t_cmd   o_cmd
);

    srit_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srit_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            srit_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = srit_pkg::S_EXEC;
                end
            end
            srit_pkg::S_EXEC: begin
                // result register must be free or draining this cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = srit_pkg::S_IDLE;
                end
            end
            default: n_state = srit_pkg::S_IDLE;
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (r_out_valid & i_out_stall);
    end

    assign o_out_valid = r_out_valid;

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == srit_pkg::S_EXEC)
        else $error("accept not followed by exec");

    a_commit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid && r_state == srit_pkg::S_IDLE)
        else $error("commit did not load result");

    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.commit))
        else $error("result appeared without commit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.commit)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

// File: rtl/srit_dp.sv
// Datapath for the tracker: mark and count/length memories, head, done flags,
// repost pointer, buffer base register and result register. Depends on srit_pkg.
`default_nettype none

module srit_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srit_pkg::t_cmd                i_cmd,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [srit_pkg::BUF_W-1:0]    i_buffer_id,
    input  wire logic [srit_pkg::OFF_W-1:0]    i_stride_offset,
    input  wire logic [srit_pkg::LEN_W-1:0]    i_byte_length,
    input  wire logic                          i_buffer_consumed,
    input  wire logic                          i_cfg_valid,
    input  wire logic [srit_pkg::ADDR_W-1:0]   i_cfg_buffer_base,
    output logic                               o_request_valid,
    output logic [srit_pkg::ADDR_W-1:0]        o_request_address,
    output logic [srit_pkg::LEN_W-1:0]         o_request_length,
    output logic                               o_reposted,
    output logic [srit_pkg::BUF_W-1:0]         o_reposted_buffer
);

    localparam int POS_W  = srit_pkg::POS_W;
    localparam int ROW_W  = srit_pkg::ROW_W;
    localparam int NROWS  = srit_pkg::NUM_ROWS;
    localparam int BUF_W  = srit_pkg::BUF_W;
    localparam int OFF_W  = srit_pkg::OFF_W;
    localparam int LEN_W  = srit_pkg::LEN_W;
    localparam int CNT_W  = srit_pkg::CNT_W;
    localparam int ADDR_W = srit_pkg::ADDR_W;
    localparam int WIW    = srit_pkg::WORD_IDX_W;

    // memories
    logic [srit_pkg::WORD_BITS-1:0] mem_mark [NROWS];
    logic [srit_pkg::CL_W-1:0]      mem_cl   [1 << POS_W];

    logic [srit_pkg::WORD_BITS-1:0] r_mark_rd;
    logic [srit_pkg::CL_W-1:0]      r_cl_rd;

    // captured item
    srit_pkg::t_mode     r_mode;
    logic [BUF_W-1:0]    r_buf;
    logic [OFF_W-1:0]    r_off;
    logic [LEN_W-1:0]    r_len;
    logic                r_cons;
    logic [POS_W-1:0]    r_pos;

    // control state
    logic [POS_W-1:0]       r_head, n_head;
    logic [BUF_W-1:0]       r_rep_ptr, n_rep_ptr;
    logic [NROWS-1:0]       r_row_vld, n_row_vld;
    logic [srit_pkg::NUM_BUFFERS-1:0] r_done, n_done;
    logic [ADDR_W-1:0]      r_base;

    logic [POS_W-1:0]    w_rd_pos;
    logic [ROW_W-1:0]    w_row;
    logic [WIW-1:0]      w_bit;
    logic [srit_pkg::WORD_BITS-1:0] w_cur_word, w_new_word;
    logic                w_take_hit;
    logic                w_rep_hit;
    logic                w_mark_we;
    logic [CNT_W-1:0]    w_cnt_new;
    logic [CNT_W-1:0]    w_cnt_rd;
    logic [LEN_W+1-1:0]  w_len_round;

    assign w_rd_pos = (srit_pkg::t_mode'(i_mode) == srit_pkg::MODE_TAKE) ? r_head
                      : {i_buffer_id, i_stride_offset};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= srit_pkg::t_mode'(i_mode);
            r_buf  <= i_buffer_id;
            r_off  <= i_stride_offset;
            r_len  <= i_byte_length;
            r_cons <= i_buffer_consumed;
            r_pos  <= w_rd_pos;
        end
    end

    // mark word memory: read on accept, write back on commit of a receive or a taken mark
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mark_rd <= mem_mark[w_rd_pos[POS_W-1:WIW]];
        end
        if (w_mark_we) begin
            mem_mark[w_row] <= w_new_word;
        end
    end

    // count/length memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cl_rd <= mem_cl[r_head];
        end
        if (i_cmd.commit && r_mode == srit_pkg::MODE_RECV) begin
            mem_cl[r_pos] <= {w_cnt_new, r_len};
        end
    end

    assign w_row      = r_pos[POS_W-1:WIW];
    assign w_bit      = r_pos[WIW-1:0];
    // a row without its valid flop set reads as all cleared
    assign w_cur_word = r_row_vld[w_row] ? r_mark_rd : '0;
    assign w_take_hit = (r_mode == srit_pkg::MODE_TAKE) && w_cur_word[w_bit];
    assign w_rep_hit  = (r_mode == srit_pkg::MODE_REPOST) && r_done[r_rep_ptr];
    assign w_mark_we  = i_cmd.commit && (r_mode == srit_pkg::MODE_RECV || w_take_hit);
    assign w_cnt_rd   = r_cl_rd[LEN_W +: CNT_W];

    always_comb begin
        w_new_word = w_cur_word;
        w_new_word[w_bit] = (r_mode == srit_pkg::MODE_RECV);
    end

    assign w_len_round = {1'b0, r_len} + (LEN_W+1)'(srit_pkg::STRIDE_BYTES - 1);
    assign w_cnt_new   = r_cons
        ? CNT_W'(srit_pkg::STRIDES_PER_BUFFER) - CNT_W'(r_off)
        : CNT_W'(w_len_round >> srit_pkg::STRIDE_SH);

    always_comb begin
        n_head    = r_head;
        n_rep_ptr = r_rep_ptr;
        n_row_vld = r_row_vld;
        n_done    = r_done;
        if (i_cmd.commit) begin
            case (r_mode)
                srit_pkg::MODE_RECV: begin
                    n_row_vld[w_row] = 1'b1;
                    if (r_cons) begin
                        n_done[r_buf] = 1'b1;
                    end
                end
                srit_pkg::MODE_NOOP: begin
                    n_done[r_buf] = 1'b1;
                    // round head up to next buffer start; buffer index wraps
                    if (r_head[POS_W-1:OFF_W] == r_buf && r_head[OFF_W-1:0] != '0) begin
                        n_head = {r_head[POS_W-1:OFF_W] + BUF_W'(1), {OFF_W{1'b0}}};
                    end
                end
                srit_pkg::MODE_TAKE: begin
                    if (w_take_hit) begin
                        n_head = r_head + POS_W'(w_cnt_rd);
                    end
                end
                default: begin
                    if (w_rep_hit) begin
                        for (int i = 0; i < NROWS; i++) begin
                            if (BUF_W'(i >> srit_pkg::ROW_SH) == r_rep_ptr) begin
                                n_row_vld[i] = 1'b0;
                            end
                        end
                        n_done[r_rep_ptr] = 1'b0;
                        n_rep_ptr         = r_rep_ptr + BUF_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_rep_ptr <= '0;
            r_row_vld <= '0;
            r_done    <= '0;
            r_base    <= '0;
        end else begin
            r_head    <= n_head;
            r_rep_ptr <= n_rep_ptr;
            r_row_vld <= n_row_vld;
            r_done    <= n_done;
            if (i_cfg_valid) begin
                r_base <= i_cfg_buffer_base;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_request_valid   <= w_take_hit;
            o_request_address <= w_take_hit
                ? r_base + ADDR_W'({r_pos, {srit_pkg::STRIDE_SH{1'b0}}}) : '0;
            o_request_length  <= w_take_hit ? r_cl_rd[LEN_W-1:0] : '0;
            o_reposted        <= w_rep_hit;
            o_reposted_buffer <= w_rep_hit ? r_rep_ptr : '0;
        end
    end

    a_take_clears_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_take_hit) |-> w_mark_we && !w_new_word[w_bit])
        else $error("taken mark not cleared");

    a_head_moves_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> $stable(r_head))
        else $error("head moved outside commit");

    a_repost_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_rep_hit) |=> !r_done[$past(r_rep_ptr)]
            && r_rep_ptr == $past(r_rep_ptr) + BUF_W'(1))
        else $error("repost bookkeeping wrong");

endmodule

`default_nettype wire

// File: rtl/striding_receive_in_order_tracker_core.sv
// Top level of the striding receive in-order tracker.
// Depends on srit_pkg, srit_ctrl and srit_dp.
//
// Each beat on the input channel is one step: receive completion, no-op
// completion, take request or repost request; each step returns exactly one
// result beat. On acceptance (idle state) the 64-bit mark word and the
// count/length entry are read (single read port each); the exec state then
// does the read-modify-write and loads the result register, waiting while a
// stalled result still holds it. One item is in flight at a time, so no new
// item is accepted until the last one has committed. Arrival marks live in a
// 256 x 64 memory with a valid flop per row, so reset and repost clear marks
// at once with no clearing pass. buffer_base is written through the config
// channel, which is always ready, and must only be written while idle.
`default_nettype none

module striding_receive_in_order_tracker_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [srit_pkg::BUF_W-1:0]    i_buffer_id,
    input  wire logic [srit_pkg::OFF_W-1:0]    i_stride_offset,
    input  wire logic [srit_pkg::LEN_W-1:0]    i_byte_length,
    input  wire logic                          i_buffer_consumed,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_request_valid,
    output logic [srit_pkg::ADDR_W-1:0]        o_request_address,
    output logic [srit_pkg::LEN_W-1:0]         o_request_length,
    output logic                               o_reposted,
    output logic [srit_pkg::BUF_W-1:0]         o_reposted_buffer,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [srit_pkg::ADDR_W-1:0]   i_cfg_buffer_base
);

    srit_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    srit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    srit_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_mode            (i_mode),
        .i_buffer_id       (i_buffer_id),
        .i_stride_offset   (i_stride_offset),
        .i_byte_length     (i_byte_length),
        .i_buffer_consumed (i_buffer_consumed),
        .i_cfg_valid       (i_cfg_valid & o_cfg_ready),
        .i_cfg_buffer_base (i_cfg_buffer_base),
        .o_request_valid   (o_request_valid),
        .o_request_address (o_request_address),
        .o_request_length  (o_request_length),
        .o_reposted        (o_reposted),
        .o_reposted_buffer (o_reposted_buffer)
    );

endmodule

`default_nettype wire
